### rtl/core/radius_neighbour_view_tracker_assert.svh
// ---------------------------------------------------------------------------
// radius neighbour view tracker assertion macros
// Shorthand for the concurrent checks used inside the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef RADIUS_NEIGHBOUR_VIEW_TRACKER_ASSERT_SVH
`define RADIUS_NEIGHBOUR_VIEW_TRACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RNVT_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RNVT_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rnvt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rnvt_pkg
// Field widths, opcodes and result kinds of the radius neighbour view tracker.
// ---------------------------------------------------------------------------
package rnvt_pkg;

  // input item fields
  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 5;
  localparam int POS_W    = 16;

  // bit offsets inside the input tdata
  localparam int OPCODE_LSB = 0;
  localparam int SLOT_LSB   = OPCODE_LSB + OPCODE_W;
  localparam int POS_X_LSB  = SLOT_LSB + SLOT_W;
  localparam int POS_Y_LSB  = POS_X_LSB + POS_W;
  localparam int IN_TDATA_W = 40;

  // result item fields
  localparam int KIND_W      = 3;
  localparam int OUT_TDATA_W = 8;

  // view radius register
  localparam int          RADIUS_W     = 16;
  localparam int          RADIUS_SQ_W  = 2 * RADIUS_W;
  localparam logic [15:0] RADIUS_RESET = 16'd160;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_PLACE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_MOVE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DONE  = 3'd0,
    KIND_NEW   = 3'd1,
    KIND_KEPT  = 3'd2,
    KIND_LEFT  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

endpackage

### rtl/core/radius_neighbour_view_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radius_neighbour_view_tracker
// Entity table with positions and per-entity view sets, answering radius
// queries with new, kept and left-view events.
// ---------------------------------------------------------------------------
// One item is handled at a time. Place, move, the unused opcode and any item
// that ends in an error give one result. The coordinate memory has one read
// port, so a query's scan reads one stored position per cycle while the
// output does not stall it, through the distance pipeline (difference,
// squares, compare); in-view results leave during the scan, left-view
// results one per cycle after it while the output is free, then the final
// done result while the new view set is written back. A wait on the result
// side can hold the scan. Input can be taken again as soon as the last result
// sits in the output register. The view store needs no clearing pass after
// reset: each entry carries a valid bit that reset clears.
// ---------------------------------------------------------------------------
`include "radius_neighbour_view_tracker_assert.svh"

module radius_neighbour_view_tracker #(
  parameter int MAX_ENTITIES = 32,
  parameter int COORD_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // view radius register
  input  logic                                cfg_we,
  input  logic [rnvt_pkg::RADIUS_W-1:0]       cfg_wdata,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // opcode[1:0], entity_slot[6:2], pos_x[22:7], pos_y[38:23], zero[39]
  input  logic [rnvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // other_slot[4:0], zero[7:5]
  output logic [rnvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind[2:0]
  output logic [rnvt_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int N       = MAX_ENTITIES;
  localparam int IDX_W   = $clog2(MAX_ENTITIES);
  localparam int CNT_W   = $clog2(MAX_ENTITIES + 1);
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int CMP_W   = (SQ_W + 1 > rnvt_pkg::RADIUS_SQ_W) ? SQ_W + 1
                                                             : rnvt_pkg::RADIUS_SQ_W;
  localparam int SLOT_W  = rnvt_pkg::SLOT_W;
  localparam int OUT_W   = rnvt_pkg::OUT_TDATA_W;
  localparam int R2_W    = rnvt_pkg::RADIUS_SQ_W;
  localparam logic [N-1:0]     ONE_N    = {{(N-1){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ENTITIES);

  // control sequencer
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SINGLE = 6'b000010,
    ST_SELF   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_LEFT   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t                      state;
  logic [rnvt_pkg::RADIUS_W-1:0] view_radius;
  logic [N-1:0]                present;
  logic [N-1:0]                pv_valid;
  logic [IDX_W-1:0]            q_slot;
  rnvt_pkg::kind_t             res_kind;
  logic [COORD_BITS-1:0]       self_x;
  logic [COORD_BITS-1:0]       self_y;
  logic [N-1:0]                prior_vec;
  logic [N-1:0]                now_vec;
  logic [N-1:0]                left_vec;
  logic [R2_W-1:0]             r2;
  logic [CNT_W-1:0]            rd_cnt;

  // distance pipeline
  logic                        s1_valid;
  logic [IDX_W-1:0]            s1_idx;
  logic                        s2_valid;
  logic [IDX_W-1:0]            s2_idx;
  logic [COORD_BITS-1:0]       s2_dx;
  logic [COORD_BITS-1:0]       s2_dy;
  logic                        s3_valid;
  logic [IDX_W-1:0]            s3_idx;
  logic [SQ_W-1:0]             s3_sqx;
  logic [SQ_W-1:0]             s3_sqy;

  // output register
  rnvt_pkg::kind_t             out_kind;
  logic [SLOT_W-1:0]           out_other;
  logic                        out_last;

  // input field decode
  logic [rnvt_pkg::OPCODE_W-1:0] in_op;
  logic [SLOT_W-1:0]             in_slot;
  logic [rnvt_pkg::POS_W-1:0]    in_pos_x;
  logic [rnvt_pkg::POS_W-1:0]    in_pos_y;
  logic [IDX_W-1:0]              in_addr;
  logic                          in_slot_ok;
  logic                          in_present;
  logic                          accept;

  assign in_op    = s_axis_tdata[rnvt_pkg::OPCODE_LSB +: rnvt_pkg::OPCODE_W];
  assign in_slot  = s_axis_tdata[rnvt_pkg::SLOT_LSB +: SLOT_W];
  assign in_pos_x = s_axis_tdata[rnvt_pkg::POS_X_LSB +: rnvt_pkg::POS_W];
  assign in_pos_y = s_axis_tdata[rnvt_pkg::POS_Y_LSB +: rnvt_pkg::POS_W];
  assign in_addr  = IDX_W'(in_slot);
  assign in_slot_ok = (32'(in_slot) < 32'(MAX_ENTITIES));
  assign in_present = in_slot_ok && present[in_addr];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // memories: positions and saved view sets
  logic                        coord_we;
  logic                        coord_re;
  logic [IDX_W-1:0]            coord_raddr;
  logic [2*COORD_BITS-1:0]     coord_rdata;
  logic                        pv_we;
  logic                        pv_re;
  logic [N-1:0]                pv_rdata;

  // output slot and pipeline advance
  logic                        ofree;
  logic                        hit3;
  logic                        adv;
  logic                        issuing;
  logic [CMP_W-1:0]            dist_sq;

  assign ofree   = !m_axis_tvalid || m_axis_tready;
  assign dist_sq = CMP_W'(s3_sqx) + CMP_W'(s3_sqy);
  assign hit3    = (dist_sq <= CMP_W'(r2));
  assign adv     = !(s3_valid && hit3) || ofree;
  assign issuing = (state == ST_SCAN) && (rd_cnt != CNT_LAST);

  assign coord_we    = accept && in_slot_ok &&
                       ((in_op == rnvt_pkg::OP_PLACE) ||
                        ((in_op == rnvt_pkg::OP_MOVE) && present[in_addr]));
  assign coord_re    = (accept && (in_op == rnvt_pkg::OP_QUERY)) || (issuing && adv);
  assign coord_raddr = (state == ST_SCAN) ? rd_cnt[IDX_W-1:0] : in_addr;
  assign pv_re       = accept && (in_op == rnvt_pkg::OP_QUERY);
  assign pv_we       = (state == ST_DONE) && ofree;

  rnvt_ram #(
    .DATA_W (2 * COORD_BITS),
    .DEPTH  (MAX_ENTITIES)
  ) u_coord_ram (
    .clk   (clk),
    .we    (coord_we),
    .waddr (in_addr),
    .wdata ({COORD_BITS'(in_pos_y), COORD_BITS'(in_pos_x)}),
    .re    (coord_re),
    .raddr (coord_raddr),
    .rdata (coord_rdata)
  );

  rnvt_ram #(
    .DATA_W (MAX_ENTITIES),
    .DEPTH  (MAX_ENTITIES)
  ) u_view_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (q_slot),
    .wdata (now_vec),
    .re    (pv_re),
    .raddr (in_addr),
    .rdata (pv_rdata)
  );

  // stage 1 compare inputs
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  logic                  skip1;

  assign rd_x  = coord_rdata[COORD_BITS-1:0];
  assign rd_y  = coord_rdata[2*COORD_BITS-1:COORD_BITS];
  assign skip1 = (s1_idx == q_slot) || !present[s1_idx];

  // lowest left-view entity
  logic [N-1:0]     low_onehot;
  logic [IDX_W-1:0] left_idx;

  always_comb begin
    low_onehot = left_vec & (~left_vec + ONE_N);
    left_idx   = '0;
    for (int i = 0; i < N; i++) begin
      left_idx = left_idx | (low_onehot[i] ? IDX_W'(i) : '0);
    end
  end

  // next result for the output register
  logic              out_load;
  rnvt_pkg::kind_t   out_kind_next;
  logic [SLOT_W-1:0] out_other_next;
  logic              out_last_next;

  always_comb begin
    out_load       = 1'b0;
    out_kind_next  = rnvt_pkg::KIND_DONE;
    out_other_next = '0;
    out_last_next  = 1'b0;
    unique case (state)
      ST_SINGLE: begin
        out_load      = 1'b1;
        out_kind_next = res_kind;
        out_last_next = 1'b1;
      end
      ST_SCAN: begin
        out_load       = s3_valid && hit3;
        out_kind_next  = prior_vec[s3_idx] ? rnvt_pkg::KIND_KEPT : rnvt_pkg::KIND_NEW;
        out_other_next = SLOT_W'(s3_idx);
      end
      ST_LEFT: begin
        out_load       = (left_vec != '0);
        out_kind_next  = rnvt_pkg::KIND_LEFT;
        out_other_next = SLOT_W'(left_idx);
      end
      ST_DONE: begin
        out_load      = 1'b1;
        out_last_next = 1'b1;
      end
      ST_IDLE: begin
        out_load = 1'b0;
      end
      ST_SELF: begin
        out_load = 1'b0;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // output register, refilled whenever it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ofree) begin
      m_axis_tvalid <= out_load;
      out_kind      <= out_kind_next;
      out_other     <= out_other_next;
      out_last      <= out_last_next;
    end
  end

  assign m_axis_tdata = OUT_W'(out_other);
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

  // view radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      view_radius <= rnvt_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      view_radius <= cfg_wdata;
    end
  end

  // distance pipeline: difference, squares, compare at the output
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issuing;
      s1_idx   <= rd_cnt[IDX_W-1:0];
      s2_valid <= s1_valid && !skip1;
      s2_idx   <= s1_idx;
      s2_dx    <= (rd_x >= self_x) ? rd_x - self_x : self_x - rd_x;
      s2_dy    <= (rd_y >= self_y) ? rd_y - self_y : self_y - rd_y;
      s3_valid <= s2_valid;
      s3_idx   <= s2_idx;
      s3_sqx   <= SQ_W'(s2_dx) * SQ_W'(s2_dx);
      s3_sqy   <= SQ_W'(s2_dy) * SQ_W'(s2_dy);
    end
  end

  // sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      present  <= '0;
      pv_valid <= '0;
      rd_cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            q_slot <= in_addr;
            state  <= ST_SINGLE;
            case (in_op)
              rnvt_pkg::OP_PLACE: begin
                if (in_slot_ok) begin
                  present[in_addr]  <= 1'b1;
                  pv_valid[in_addr] <= 1'b0;
                  res_kind          <= rnvt_pkg::KIND_DONE;
                end else begin
                  res_kind <= rnvt_pkg::KIND_ERROR;
                end
              end
              rnvt_pkg::OP_MOVE: begin
                res_kind <= in_present ? rnvt_pkg::KIND_DONE : rnvt_pkg::KIND_ERROR;
              end
              rnvt_pkg::OP_QUERY: begin
                res_kind <= rnvt_pkg::KIND_ERROR;
                if (in_present) begin
                  state <= ST_SELF;
                end
              end
              default: begin
                res_kind <= rnvt_pkg::KIND_DONE;
              end
            endcase
          end
        end
        ST_SINGLE: begin
          if (ofree) begin
            state <= ST_IDLE;
          end
        end
        ST_SELF: begin
          self_x    <= rd_x;
          self_y    <= rd_y;
          prior_vec <= pv_valid[q_slot] ? pv_rdata : '0;
          r2        <= R2_W'(view_radius) * R2_W'(view_radius);
          now_vec   <= '0;
          rd_cnt    <= '0;
          state     <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issuing && adv) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (s3_valid && hit3 && adv) begin
            now_vec[s3_idx] <= 1'b1;
          end
          if (!issuing && !s1_valid && !s2_valid && !s3_valid) begin
            left_vec <= prior_vec & ~now_vec;
            state    <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          if (left_vec == '0) begin
            state <= ST_DONE;
          end else if (ofree) begin
            left_vec <= left_vec & ~low_onehot;
          end
        end
        ST_DONE: begin
          if (ofree) begin
            pv_valid[q_slot] <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `RNVT_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, accept, !s_axis_tready,
    "input taken again right after a transfer")
  `RNVT_ASSERT_NEXT(a_hit_held_on_stall, clk, rst, s3_valid && hit3 && !ofree,
    s3_valid && (s3_idx == $past(s3_idx)), "in-view hit dropped while output stalled")
  `RNVT_ASSERT_IMPL(a_scan_drained, clk, rst, state == ST_LEFT,
    !s1_valid && !s2_valid && !s3_valid, "left-view pass started with scan in flight")
  `RNVT_ASSERT_IMPL(a_left_all_sent, clk, rst, state == ST_DONE, left_vec == '0,
    "query finished with left-view entities unreported")

endmodule

### rtl/core/rnvt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rnvt_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rnvt_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
